// ===== rtl/core/mbid_pkg.sv =====
// ----------------------------------------------------------------------------
// mbid_pkg
// shared constants for the multi-button integrating debouncer
// ----------------------------------------------------------------------------
`default_nettype none

package mbid_pkg;

    localparam int NUM_FRETS_DEF = 5;
    localparam int CNT_W         = 4;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 4'd3;
    localparam logic [CNT_W-1:0] THRESHOLD_MIN   = 4'd1;

endpackage

`default_nettype wire

// ===== rtl/core/multi_button_integrating_debouncer_top.sv =====
// ----------------------------------------------------------------------------
// multi_button_integrating_debouncer_top
// integrating up/down counter debouncer for fret and strum buttons, with a
// lowest-held-fret encoder; one result per sampling tick
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (lsb first)
// s_        in   raw_buttons[NUM_FRETS:0]
// m_        out  press_mask, release_mask, held_mask, strum_pressed,
//                strum_released, current_fret, fret_changed
// cfg_wr_   in   debounce_threshold[3:0]
//
// one request per cycle sustained while m_tready stays high; stages: input
// register, then the counter update and fret encoder, then the result register.
// aresetn clears counters, debounced state, previous fret (none) and sets the
// threshold to 3.
// a stalled result holds in the result register while the input register
// still takes one more request.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_button_integrating_debouncer_top #(
    parameter int NUM_FRETS = mbid_pkg::NUM_FRETS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [mbid_pkg::CNT_W-1:0] cfg_wr_data,  // debounce_threshold

    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [((NUM_FRETS+8)/8)*8-1:0] s_tdata,  // raw_buttons, zero pad

    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // press_mask, release_mask, held_mask, strum_pressed, strum_released,
    // current_fret, fret_changed, zero pad
    output      logic [((3*NUM_FRETS+3+$clog2(NUM_FRETS+1)+7)/8)*8-1:0] m_tdata
);

    localparam int CNT_W    = mbid_pkg::CNT_W;
    localparam int NCH      = NUM_FRETS + 1;
    localparam int FRET_W   = $clog2(NUM_FRETS + 1);
    localparam int OUT_BITS = 3*NUM_FRETS + 3 + FRET_W;
    localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [FRET_W-1:0] NO_FRET = FRET_W'(NUM_FRETS);

    logic [CNT_W-1:0]     thr_reg;
    logic [CNT_W-1:0]     thr_eff;

    logic                 in_valid_reg, in_valid_next;
    logic [NCH-1:0]       in_raw_reg;

    logic [CNT_W-1:0]     cnt_reg  [NCH];
    logic [CNT_W-1:0]     cnt_next [NCH];
    logic [NCH-1:0]       deb_reg, deb_next;
    logic [NCH-1:0]       press_vec, release_vec;
    logic [FRET_W-1:0]    prev_fret_reg;
    logic [FRET_W-1:0]    low_fret;
    logic                 fret_chg;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_DW-1:0]    out_data_reg, out_data_next;

    logic                 s_fire;
    logic                 advance;

    assign thr_eff  = (thr_reg == '0) ? mbid_pkg::THRESHOLD_MIN : thr_reg;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // per-channel integrating counters
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            cnt_next[i] = cnt_reg[i];
            if (in_raw_reg[i]) begin
                if (cnt_reg[i] < thr_eff) begin
                    cnt_next[i] = cnt_reg[i] + 1'b1;
                end
            end else if (cnt_reg[i] != '0) begin
                cnt_next[i] = cnt_reg[i] - 1'b1;
            end
            deb_next[i]    = deb_reg[i];
            press_vec[i]   = 1'b0;
            release_vec[i] = 1'b0;
            if (cnt_next[i] >= thr_eff && !deb_reg[i]) begin
                deb_next[i]  = 1'b1;
                press_vec[i] = 1'b1;
            end else if (cnt_next[i] == '0 && deb_reg[i]) begin
                deb_next[i]    = 1'b0;
                release_vec[i] = 1'b1;
            end
        end
    end

    // lowest held fret
    always_comb begin
        low_fret = NO_FRET;
        for (int i = NUM_FRETS - 1; i >= 0; i--) begin
            if (deb_next[i]) begin
                low_fret = FRET_W'(i);
            end
        end
        fret_chg = (low_fret != prev_fret_reg);
    end

    always_comb begin
        out_data_next = '0;
        out_data_next[OUT_BITS-1:0] = {fret_chg, low_fret,
                                       release_vec[NUM_FRETS], press_vec[NUM_FRETS],
                                       deb_next[NUM_FRETS-1:0],
                                       release_vec[NUM_FRETS-1:0],
                                       press_vec[NUM_FRETS-1:0]};
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= mbid_pkg::THRESHOLD_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            deb_reg       <= '0;
            prev_fret_reg <= NO_FRET;
            for (int i = 0; i < NCH; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                deb_reg       <= deb_next;
                prev_fret_reg <= low_fret;
                for (int i = 0; i < NCH; i++) begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_raw_reg <= s_tdata[NCH-1:0];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // a channel never reports press and release on the same tick
    a_press_release_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> ((press_vec & release_vec) == '0))
        else $error("press and release on same channel");

    // stored fret code stays within range
    a_prev_fret_range: assert property (@(posedge aclk) disable iff (!aresetn)
        prev_fret_reg <= NO_FRET)
        else $error("previous fret out of range");

    // newly set debounced bits are exactly the press flags
    a_deb_set: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> ((deb_reg & ~$past(deb_reg)) == $past(press_vec)))
        else $error("debounced set without press");

    // a full input stage behind a stalled result holds off new requests
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("request accepted while both stages full");

    // a result leaves the result register only after it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
